FILE: hdl/e2cdt_pkg.sv
`default_nettype none

package e2cdt_pkg;

   localparam int NUM_STAGES = 10;

   localparam int EPOCH_W  = 32;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   localparam int DAYS_W = 16;
   localparam int SOD_W  = 17;
   localparam int DOE_W  = 18;
   localparam int Z_W    = 20;
   localparam int MSOD_W = 12;
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   localparam int MP_W   = 4;

   // 86400 = 675 << 7
   localparam int DAY_LO_BITS = 7;
   localparam int DAY_ODD     = 675;

   localparam int DAY_SHIFT         = 719468;
   localparam int DAYS_PER_ERA      = 146097;
   localparam int ERA_LAST_DAY      = 146096;
   localparam int DAYS_PER_CENTURY  = 36524;
   localparam int DAYS_PER_QUAD_M1  = 1460;
   localparam int DAYS_PER_YEAR     = 365;
   localparam int SECS_PER_HOUR     = 3600;
   localparam int SECS_PER_MIN      = 60;
   localparam int ERA_LOW           = 4;
   localparam int YEARS_PER_ERA     = 400;

   // rounded-up reciprocals, exact over the operand ranges in use
   localparam int SH_DAY  = 35;
   localparam int SH_1460 = 29;
   localparam int SH_3600 = 29;
   localparam int SH_365  = 28;
   localparam int SH_60   = 18;
   localparam int SH_100  = 16;
   localparam int SH_153  = 19;
   localparam int SH_5    = 14;

   localparam logic [25:0] RCP_DAY =
      26'(((64'd1 << SH_DAY) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
   localparam logic [18:0] RCP_1460 =
      19'(((64'd1 << SH_1460) + 64'(DAYS_PER_QUAD_M1) - 64'd1) / 64'(DAYS_PER_QUAD_M1));
   localparam logic [17:0] RCP_3600 =
      18'(((64'd1 << SH_3600) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
   localparam logic [19:0] RCP_365 =
      20'(((64'd1 << SH_365) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
   localparam logic [12:0] RCP_60 =
      13'(((64'd1 << SH_60) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
   localparam logic [9:0] RCP_100 =
      10'(((64'd1 << SH_100) + 64'd99) / 64'd100);
   localparam logic [11:0] RCP_153 =
      12'(((64'd1 << SH_153) + 64'd152) / 64'd153);
   localparam logic [11:0] RCP_5 =
      12'(((64'd1 << SH_5) + 64'd4) / 64'd5);

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } hms_type;

endpackage

`default_nettype wire

FILE: hdl/epoch_to_civil_datetime_unit.sv
// an accepted item is registered through each stage in order before its result reaches the rsp channel
// throughput: one item per cycle while the output does not stall, through the ten-stage conversion pipeline
// stages advance independently, so bubbles collapse under a stalled output
// reset (synchronous, active high) clears every stage valid bit
`default_nettype none

module epoch_to_civil_datetime_unit
   import e2cdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [EPOCH_W-1:0]  req_epoch_seconds,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [YEAR_W-1:0]        rsp_year,
   output logic [MONTH_W-1:0]       rsp_month,
   output logic [DAY_W-1:0]         rsp_day,
   output logic [HOUR_W-1:0]        rsp_hour,
   output logic [MINUTE_W-1:0]      rsp_minute,
   output logic [SECOND_W-1:0]      rsp_second
);

   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: whole days
   logic [50:0]          s1_prod;
   logic [DAYS_W-1:0]    s1_days_in, s1_days_ff;
   logic [EPOCH_W-1:0]   s1_secs_ff;

   assign s1_prod    = 51'(req_epoch_seconds[EPOCH_W-1:DAY_LO_BITS]) * 51'(RCP_DAY);
   assign s1_days_in = s1_prod[SH_DAY +: DAYS_W];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_days_ff <= s1_days_in;
         s1_secs_ff <= req_epoch_seconds;
      end
   end

   // stage 2: seconds of day, era and day of era
   logic [24:0]          s2_rem;
   logic [Z_W-1:0]       s2_z;
   logic                 s2_era5_in, s2_era5_ff;
   logic [SOD_W-1:0]     s2_sod_in, s2_sod_ff;
   logic [DOE_W-1:0]     s2_doe_in, s2_doe_ff;

   always_comb begin
      s2_rem     = s1_secs_ff[EPOCH_W-1:DAY_LO_BITS] - 25'(s1_days_ff) * 25'(DAY_ODD);
      s2_sod_in  = {s2_rem[SOD_W-DAY_LO_BITS-1:0], s1_secs_ff[DAY_LO_BITS-1:0]};
      s2_z       = Z_W'(s1_days_ff) + Z_W'(DAY_SHIFT);
      s2_era5_in = s2_z >= Z_W'((ERA_LOW + 1) * DAYS_PER_ERA);
      s2_doe_in  = s2_era5_in ? DOE_W'(s2_z - Z_W'((ERA_LOW + 1) * DAYS_PER_ERA))
                              : DOE_W'(s2_z - Z_W'(ERA_LOW * DAYS_PER_ERA));
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_sod_ff  <= s2_sod_in;
         s2_doe_ff  <= s2_doe_in;
         s2_era5_ff <= s2_era5_in;
      end
   end

   // stage 3: leap corrections of the era, hour
   logic [36:0]          s3_qprod;
   logic [34:0]          s3_hprod;
   logic [6:0]           s3_quad_in, s3_quad_ff;
   logic [2:0]           s3_cent_in, s3_cent_ff;
   logic                 s3_last_in, s3_last_ff;
   logic [HOUR_W-1:0]    s3_hour_in, s3_hour_ff;
   logic [DOE_W-1:0]     s3_doe_ff;
   logic [SOD_W-1:0]     s3_sod_ff;
   logic                 s3_era5_ff;

   always_comb begin
      s3_qprod   = 37'(s2_doe_ff) * 37'(RCP_1460);
      s3_quad_in = s3_qprod[SH_1460 +: 7];
      s3_cent_in = 3'(s2_doe_ff >= DOE_W'(DAYS_PER_CENTURY))
                 + 3'(s2_doe_ff >= DOE_W'(2 * DAYS_PER_CENTURY))
                 + 3'(s2_doe_ff >= DOE_W'(3 * DAYS_PER_CENTURY))
                 + 3'(s2_doe_ff >= DOE_W'(4 * DAYS_PER_CENTURY));
      s3_last_in = s2_doe_ff >= DOE_W'(ERA_LAST_DAY);
      s3_hprod   = 35'(s2_sod_ff) * 35'(RCP_3600);
      s3_hour_in = s3_hprod[SH_3600 +: HOUR_W];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_quad_ff <= s3_quad_in;
         s3_cent_ff <= s3_cent_in;
         s3_last_ff <= s3_last_in;
         s3_hour_ff <= s3_hour_in;
         s3_doe_ff  <= s2_doe_ff;
         s3_sod_ff  <= s2_sod_ff;
         s3_era5_ff <= s2_era5_ff;
      end
   end

   // stage 4: corrected day of era, seconds of hour
   logic [DOE_W-1:0]     s4_t_in, s4_t_ff;
   logic [SOD_W-1:0]     s4_hsec;
   logic [MSOD_W-1:0]    s4_msod_in, s4_msod_ff;
   logic [DOE_W-1:0]     s4_doe_ff;
   logic                 s4_era5_ff;
   logic [HOUR_W-1:0]    s4_hour_ff;

   always_comb begin
      s4_t_in    = s3_doe_ff + DOE_W'(s3_cent_ff) - DOE_W'(s3_quad_ff) - DOE_W'(s3_last_ff);
      s4_hsec    = SOD_W'(s3_hour_ff) * SOD_W'(SECS_PER_HOUR);
      s4_msod_in = MSOD_W'(s3_sod_ff - s4_hsec);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_t_ff    <= s4_t_in;
         s4_msod_ff <= s4_msod_in;
         s4_doe_ff  <= s3_doe_ff;
         s4_era5_ff <= s3_era5_ff;
         s4_hour_ff <= s3_hour_ff;
      end
   end

   // stage 5: year of era, minute
   logic [37:0]          s5_yprod;
   logic [24:0]          s5_mprod;
   logic [YOE_W-1:0]     s5_yoe_in, s5_yoe_ff;
   logic [MINUTE_W-1:0]  s5_minute_in, s5_minute_ff;
   logic [MSOD_W-1:0]    s5_msod_ff;
   logic [DOE_W-1:0]     s5_doe_ff;
   logic                 s5_era5_ff;
   logic [HOUR_W-1:0]    s5_hour_ff;

   always_comb begin
      s5_yprod     = 38'(s4_t_ff) * 38'(RCP_365);
      s5_yoe_in    = s5_yprod[SH_365 +: YOE_W];
      s5_mprod     = 25'(s4_msod_ff) * 25'(RCP_60);
      s5_minute_in = s5_mprod[SH_60 +: MINUTE_W];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_yoe_ff    <= s5_yoe_in;
         s5_minute_ff <= s5_minute_in;
         s5_msod_ff   <= s4_msod_ff;
         s5_doe_ff    <= s4_doe_ff;
         s5_era5_ff   <= s4_era5_ff;
         s5_hour_ff   <= s4_hour_ff;
      end
   end

   // stage 6: days before the year of era, second
   logic [18:0]          s6_cprod;
   logic [1:0]           s6_c100_in, s6_c100_ff;
   logic [DOE_W-1:0]     s6_y365_in, s6_y365_ff;
   logic [MSOD_W-1:0]    s6_msec;
   hms_type              s6_time_in, s6_time_ff;
   logic [YOE_W-1:0]     s6_yoe_ff;
   logic [DOE_W-1:0]     s6_doe_ff;
   logic                 s6_era5_ff;

   always_comb begin
      s6_cprod          = 19'(s5_yoe_ff) * 19'(RCP_100);
      s6_c100_in        = s6_cprod[SH_100 +: 2];
      s6_y365_in        = DOE_W'(s5_yoe_ff) * DOE_W'(DAYS_PER_YEAR);
      s6_msec           = MSOD_W'(s5_minute_ff) * MSOD_W'(SECS_PER_MIN);
      s6_time_in.hour   = s5_hour_ff;
      s6_time_in.minute = s5_minute_ff;
      s6_time_in.second = SECOND_W'(s5_msod_ff - s6_msec);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_c100_ff <= s6_c100_in;
         s6_y365_ff <= s6_y365_in;
         s6_time_ff <= s6_time_in;
         s6_yoe_ff  <= s5_yoe_ff;
         s6_doe_ff  <= s5_doe_ff;
         s6_era5_ff <= s5_era5_ff;
      end
   end

   // stage 7: day of March-based year
   logic [18:0]          s7_before;
   logic [DOY_W-1:0]     s7_doy_in, s7_doy_ff;
   hms_type              s7_time_ff;
   logic [YOE_W-1:0]     s7_yoe_ff;
   logic                 s7_era5_ff;

   always_comb begin
      s7_before = 19'(s6_y365_ff) + 19'(s6_yoe_ff >> 2) - 19'(s6_c100_ff);
      s7_doy_in = DOY_W'(19'(s6_doe_ff) - s7_before);
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_doy_ff  <= s7_doy_in;
         s7_time_ff <= s6_time_ff;
         s7_yoe_ff  <= s6_yoe_ff;
         s7_era5_ff <= s6_era5_ff;
      end
   end

   // stage 8: March-based month
   logic [10:0]          s8_num;
   logic [22:0]          s8_prod;
   logic [MP_W-1:0]      s8_mp_in, s8_mp_ff;
   logic [DOY_W-1:0]     s8_doy_ff;
   hms_type              s8_time_ff;
   logic [YOE_W-1:0]     s8_yoe_ff;
   logic                 s8_era5_ff;

   always_comb begin
      s8_num   = 11'(s7_doy_ff) * 11'd5 + 11'd2;
      s8_prod  = 23'(s8_num) * 23'(RCP_153);
      s8_mp_in = s8_prod[SH_153 +: MP_W];
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_mp_ff   <= s8_mp_in;
         s8_doy_ff  <= s7_doy_ff;
         s8_time_ff <= s7_time_ff;
         s8_yoe_ff  <= s7_yoe_ff;
         s8_era5_ff <= s7_era5_ff;
      end
   end

   // stage 9: days before the month, scaled by five
   logic [10:0]          s9_p_in, s9_p_ff;
   logic [MP_W-1:0]      s9_mp_ff;
   logic [DOY_W-1:0]     s9_doy_ff;
   hms_type              s9_time_ff;
   logic [YOE_W-1:0]     s9_yoe_ff;
   logic                 s9_era5_ff;

   assign s9_p_in = 11'(s8_mp_ff) * 11'd153 + 11'd2;

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s9_p_ff    <= s9_p_in;
         s9_mp_ff   <= s8_mp_ff;
         s9_doy_ff  <= s8_doy_ff;
         s9_time_ff <= s8_time_ff;
         s9_yoe_ff  <= s8_yoe_ff;
         s9_era5_ff <= s8_era5_ff;
      end
   end

   // stage 10: calendar fields
   logic [22:0]          s10_prod;
   logic [DOY_W-1:0]     s10_mstart;
   logic [MONTH_W-1:0]   s10_month_in;
   logic [DAY_W-1:0]     s10_day_in;
   logic [YEAR_W-1:0]    s10_year_in;
   logic [YEAR_W-1:0]    s10_era_year;

   always_comb begin
      s10_prod     = 23'(s9_p_ff) * 23'(RCP_5);
      s10_mstart   = s10_prod[SH_5 +: DOY_W];
      s10_day_in   = DAY_W'(s9_doy_ff - s10_mstart + DOY_W'(1));
      s10_month_in = (s9_mp_ff < MP_W'(10)) ? MONTH_W'(s9_mp_ff + MP_W'(3))
                                            : MONTH_W'(s9_mp_ff - MP_W'(9));
      s10_era_year = s9_era5_ff ? YEAR_W'((ERA_LOW + 1) * YEARS_PER_ERA)
                                : YEAR_W'(ERA_LOW * YEARS_PER_ERA);
      s10_year_in  = YEAR_W'(s9_yoe_ff) + s10_era_year
                   + YEAR_W'(s10_month_in <= MONTH_W'(2));
   end

   logic [YEAR_W-1:0]    rsp_year_ff;
   logic [MONTH_W-1:0]   rsp_month_ff;
   logic [DAY_W-1:0]     rsp_day_ff;
   hms_type              rsp_time_ff;

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         rsp_year_ff  <= s10_year_in;
         rsp_month_ff <= s10_month_in;
         rsp_day_ff   <= s10_day_in;
         rsp_time_ff  <= s9_time_ff;
      end
   end

   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_time_ff.hour;
   assign rsp_minute = rsp_time_ff.minute;
   assign rsp_second = rsp_time_ff.second;

endmodule

`default_nettype wire

FILE: hdl/e2cdt_checker.sv
`default_nettype none

module e2cdt_checker
   import e2cdt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [YEAR_W-1:0]   rsp_year,
   input wire logic [MONTH_W-1:0]  rsp_month,
   input wire logic [DAY_W-1:0]    rsp_day,
   input wire logic [HOUR_W-1:0]   rsp_hour,
   input wire logic [MINUTE_W-1:0] rsp_minute,
   input wire logic [SECOND_W-1:0] rsp_second
);

   // a result waiting on a stall stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // input only backs up when the output holds an item
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty output");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= YEAR_W'(1970)) && (rsp_year <= YEAR_W'(2106))
                 && (rsp_month >= MONTH_W'(1)) && (rsp_month <= MONTH_W'(12))
                 && (rsp_day >= DAY_W'(1)) && (rsp_hour < HOUR_W'(24))
                 && (rsp_minute < MINUTE_W'(60)) && (rsp_second < SECOND_W'(60)))
      else $error("rsp field out of range");

endmodule

bind epoch_to_civil_datetime_unit e2cdt_checker u_e2cdt_checker (.*);

`default_nettype wire

FILE: test/epoch_to_civil_datetime_unit_tb.sv
`timescale 1ns / 100ps

module epoch_to_civil_datetime_unit_tb;
   import e2cdt_pkg::*;

   localparam int unsigned SECONDS_IN_DAY  = 86400;
   localparam int unsigned SECONDS_IN_HOUR = 3600;
   localparam int unsigned SECONDS_IN_MIN  = 60;
   localparam int unsigned MARCH_ORIGIN    = 719468;
   localparam int unsigned ERA_DAYS        = 146097;
   localparam int unsigned ERA_END_DAY     = 146096;
   localparam int unsigned CENTURY_DAYS    = 36524;
   localparam int unsigned QUAD_DAYS_M1    = 1460;
   localparam int unsigned MAX_DAY_INDEX   = 49709;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int HOLD_OFF       = 300;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } civil_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [EPOCH_W-1:0]  req_epoch_seconds = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [YEAR_W-1:0]   rsp_year;
   logic [MONTH_W-1:0]  rsp_month;
   logic [DAY_W-1:0]    rsp_day;
   logic [HOUR_W-1:0]   rsp_hour;
   logic [MINUTE_W-1:0] rsp_minute;
   logic [SECOND_W-1:0] rsp_second;

   civil_type pending_dates[$];
   int        dates_sent = 0;
   int        dates_checked = 0;
   int        date_errors = 0;
   int        quiet_cycles = 0;
   int        hold_request = 0;
   bit        sender_gaps = 1'b0;
   bit        receiver_gaps = 1'b0;

   epoch_to_civil_datetime_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

   always #5 clock = ~clock;

   function automatic civil_type civil_of_epoch(input logic [EPOCH_W-1:0] secs);
      int unsigned day_count;
      int unsigned sec_of_day;
      int unsigned shifted;
      int unsigned era;
      int unsigned day_of_era;
      int unsigned year_of_era;
      int unsigned day_of_year;
      int unsigned month_index;
      int unsigned month_num;
      civil_type   date;
      day_count   = secs / SECONDS_IN_DAY;
      sec_of_day  = secs % SECONDS_IN_DAY;
      shifted     = day_count + MARCH_ORIGIN;
      era         = shifted / ERA_DAYS;
      day_of_era  = shifted - era * ERA_DAYS;
      year_of_era = (day_of_era - day_of_era / QUAD_DAYS_M1 + day_of_era / CENTURY_DAYS
                     - day_of_era / ERA_END_DAY) / 365;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
      month_index = (5 * day_of_year + 2) / 153;
      month_num   = (month_index < 10) ? month_index + 3 : month_index - 9;
      date.day    = DAY_W'(day_of_year - (153 * month_index + 2) / 5 + 1);
      date.month  = MONTH_W'(month_num);
      date.year   = YEAR_W'(year_of_era + era * 400 + ((month_num <= 2) ? 1 : 0));
      date.hour   = HOUR_W'(sec_of_day / SECONDS_IN_HOUR);
      date.minute = MINUTE_W'((sec_of_day % SECONDS_IN_HOUR) / SECONDS_IN_MIN);
      date.second = SECOND_W'(sec_of_day % SECONDS_IN_MIN);
      return date;
   endfunction

   // sender: called at a rising edge, returns at the edge that accepts the item
   task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
      int unsigned gap;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_dates.push_back(civil_of_epoch(secs));
      dates_sent++;
   endtask

   // receiver stall bursts and the long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      civil_type got;
      civil_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second};
         if (pending_dates.size() == 0) begin
            date_errors++;
            if (date_errors <= REPORT_LIMIT) begin
               $display("unexpected item %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                        got.day, got.hour, got.minute, got.second);
            end
         end else begin
            want = pending_dates.pop_front();
            dates_checked++;
            if (got !== want) begin
               date_errors++;
               if (date_errors <= REPORT_LIMIT) begin
                  $display("item %0d: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                           dates_checked, want.year, want.month, want.day, want.hour,
                           want.minute, want.second, got.year, got.month, got.day,
                           got.hour, got.minute, got.second);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet_cycles);
         $display("epoch_to_civil_datetime_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic test_directed_dates();
      logic [EPOCH_W-1:0] corners[$];
      corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                  32'd86400, 32'd68169600, 32'd946684799, 32'd951696000,
                  32'd951782400, 32'd951868799, 32'd951868800, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'd4107456000, 32'd4107542399, 32'd4107542400,
                  32'd4134067199, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
                  32'hFFFF_FFFF};
      foreach (corners[i]) send_epoch(corners[i]);
   endtask

   function automatic logic [EPOCH_W-1:0] random_epoch();
      int unsigned kind;
      int unsigned day_index;
      kind = $urandom_range(0, 3);
      day_index = $urandom_range(0, MAX_DAY_INDEX);
      case (kind)
         0: begin
            return day_index * SECONDS_IN_DAY;
         end
         1: begin
            return day_index * SECONDS_IN_DAY + SECONDS_IN_DAY - 1 - $urandom_range(0, 3);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic test_random_with_gaps(input int count);
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      repeat (count) send_epoch(random_epoch());
   endtask

   task automatic test_output_hold_off(input int count);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_request = HOLD_OFF;
      repeat (count) send_epoch(random_epoch());
   endtask

   task automatic test_streaming(input int count);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (count) send_epoch(random_epoch());
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_dates();
      test_random_with_gaps(650);
      test_output_hold_off(60);
      test_streaming(370);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_dates.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (NUM_STAGES + 4) @(posedge clock);
      date_errors += pending_dates.size();
      $display("converted %0d timestamps: calendar corners, leap days, day edges and random",
               dates_sent);
      $display("values under random idling, a %0d-cycle output hold-off and full-rate streaming",
               HOLD_OFF);
      if (date_errors == 0) begin
         $display("epoch_to_civil_datetime_unit_tb: PASS");
      end else begin
         $display("epoch_to_civil_datetime_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/e2cdt_pkg.sv
hdl/epoch_to_civil_datetime_unit.sv
hdl/e2cdt_checker.sv
test/epoch_to_civil_datetime_unit_tb.sv
